/* src/mmbd_pkg.sv */
// Shared types and constants for the memory map bus decoder.
// No dependencies; every file but mmbd_ram imports this package.
package mmbd_pkg;

   // Store depths of the address map
   localparam int unsigned ROM_DEPTH  = 16384;
   localparam int unsigned VRAM_DEPTH = 8192;
   localparam int unsigned WRAM_DEPTH = 8192;
   localparam int unsigned OAM_DEPTH  = 160;
   localparam int unsigned IO_DEPTH   = 128;
   localparam int unsigned HRAM_DEPTH = 127;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned INDEX_W  = 14;
   localparam int unsigned REGION_W = 4;

   // Region codes
   localparam logic [REGION_W-1:0] REGION_NONE = 4'd0;
   localparam logic [REGION_W-1:0] REGION_ROM0 = 4'd1;
   localparam logic [REGION_W-1:0] REGION_ROM1 = 4'd2;
   localparam logic [REGION_W-1:0] REGION_VRAM = 4'd3;
   localparam logic [REGION_W-1:0] REGION_WRAM = 4'd4;
   localparam logic [REGION_W-1:0] REGION_OAM  = 4'd5;
   localparam logic [REGION_W-1:0] REGION_IO   = 4'd6;
   localparam logic [REGION_W-1:0] REGION_HRAM = 4'd7;
   localparam logic [REGION_W-1:0] REGION_IE   = 4'd8;

   // Decoded access: which store and which entry in it
   typedef struct packed {
      logic [REGION_W-1:0] region;
      logic [INDEX_W-1:0]  index;
   } mmbd_sel_type;

endpackage

/* src/memory_map_bus_decoder_top.sv */
// Top level of the memory map bus decoder: stream handshake, access stage
// and result register. Depends on mmbd_pkg, mmbd_decode and mmbd_store.
//
// Usage:
//   The req_ channel carries one byte bus access per transfer: req_tuser is
//   the action (0 read, 1 write), req_tdata holds the address and the write
//   byte. The rsp_ channel returns exactly one result per access, in order:
//   the byte read (zero on writes and on errors) and an error flag that is
//   set for external RAM (0xa000-0xbfff) and the unusable gap (0xfea0-0xfeff).
//   Path: a result reaches rsp_tvalid through the synchronous store read and
//   then the result register. Throughput: one access per cycle while the
//   receiver does not stall, set by the single port of each store; a write
//   and a later read of the same entry never overlap in a port, so no
//   forwarding is needed.
//   Stall: while rsp_tready is low the result register holds, the access in
//   the store stage holds its read data, and req_tready drops once both are
//   full. Nothing is lost or repeated.
//   Reset: clears the handshake state and the interrupt enable register; the
//   memories are not cleared and hold undefined bytes until written. The
//   block accepts requests in the first cycle after reset.
module memory_map_bus_decoder_top import mmbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] write_data
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic        rsp_tuser    // [0] error
);

   logic              req_accept;
   logic              stage_move;
   mmbd_sel_type      sel;
   logic [BYTE_W-1:0] store_rd;

   // store stage: one access waiting for its read data
   logic pend_ff, pend_in;
   logic write_ff;
   logic error_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_error_ff;

   mmbd_decode u_decode (
      .address(req_tdata[15:0]),
      .sel
   );

   mmbd_store u_store (
      .clock,
      .reset,
      .en(req_accept),
      .we(req_tuser),
      .sel,
      .wdata(req_tdata[23:16]),
      .rdata(store_rd)
   );

   // advance the store stage whenever the result register is free or drains
   assign stage_move = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign pend_in      = req_accept || (pend_ff && !stage_move);
   assign rsp_valid_in = stage_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the access kind with the store read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         write_ff <= req_tuser;
         error_ff <= (sel.region == REGION_NONE);
      end
   end

   // load the result; writes and unmapped accesses answer a zero byte
   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_data_ff  <= (write_ff || error_ff) ? '0 : store_rd;
         rsp_error_ff <= error_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_error_ff;

`ifndef SYNTHESIS
   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("error result carries a nonzero byte");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> pend_ff && rsp_tvalid && !rsp_tready)
      else $error("request side stalled without a full pipeline");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !rsp_tvalid |=> rsp_tvalid)
      else $error("pending access did not reach the result register");

   a_accept_yields_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> pend_ff)
      else $error("accepted access lost from the store stage");
`endif

endmodule

/* src/mmbd_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mmbd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/mmbd_decode.sv */
// Address decoder: maps a 16-bit bus address onto a store and entry index.
// Depends on mmbd_pkg.
module mmbd_decode import mmbd_pkg::*; (
   input  logic [ADDR_W-1:0] address,
   output mmbd_sel_type      sel
);

   always_comb begin
      sel.index  = address[INDEX_W-1:0];
      sel.region = REGION_NONE;
      unique case (address[15:13])
         3'b000, 3'b001: sel.region = REGION_ROM0;
         3'b010, 3'b011: sel.region = REGION_ROM1;
         3'b100:         sel.region = REGION_VRAM;
         3'b101:         sel.region = REGION_NONE;
         3'b110:         sel.region = REGION_WRAM;
         3'b111: begin
            // echo mirror up to 0xfdff, then the top page regions
            priority if (address[12:9] != 4'hf) begin
               sel.region = REGION_WRAM;
            end else if (address[8] == 1'b0) begin
               sel.region = (address[7:0] < 8'ha0) ? REGION_OAM : REGION_NONE;
            end else if (address[7] == 1'b0) begin
               sel.region = REGION_IO;
            end else if (address[6:0] == 7'h7f) begin
               sel.region = REGION_IE;
            end else begin
               sel.region = REGION_HRAM;
            end
         end
         default: sel.region = REGION_NONE;
      endcase
   end

endmodule

/* src/mmbd_store.sv */
// Backing stores of the memory map: one RAM per region plus the interrupt
// enable register. Depends on mmbd_pkg and mmbd_ram.
module mmbd_store import mmbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              we,
   input  mmbd_sel_type      sel,
   input  logic [BYTE_W-1:0] wdata,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0]   rom0_rd, rom1_rd, vram_rd, wram_rd, oam_rd, io_rd, hram_rd;
   logic [REGION_W-1:0] region_ff;
   logic [BYTE_W-1:0]   ie_ff, ie_in;
   logic [BYTE_W-1:0]   ie_rd_ff;

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(ROM_DEPTH)) u_rom0 (
      .clock, .en(en && sel.region == REGION_ROM0), .we,
      .addr(sel.index[$clog2(ROM_DEPTH)-1:0]), .wdata, .rdata(rom0_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(ROM_DEPTH)) u_rom1 (
      .clock, .en(en && sel.region == REGION_ROM1), .we,
      .addr(sel.index[$clog2(ROM_DEPTH)-1:0]), .wdata, .rdata(rom1_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(VRAM_DEPTH)) u_vram (
      .clock, .en(en && sel.region == REGION_VRAM), .we,
      .addr(sel.index[$clog2(VRAM_DEPTH)-1:0]), .wdata, .rdata(vram_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(WRAM_DEPTH)) u_wram (
      .clock, .en(en && sel.region == REGION_WRAM), .we,
      .addr(sel.index[$clog2(WRAM_DEPTH)-1:0]), .wdata, .rdata(wram_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(OAM_DEPTH)) u_oam (
      .clock, .en(en && sel.region == REGION_OAM), .we,
      .addr(sel.index[$clog2(OAM_DEPTH)-1:0]), .wdata, .rdata(oam_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(IO_DEPTH)) u_io (
      .clock, .en(en && sel.region == REGION_IO), .we,
      .addr(sel.index[$clog2(IO_DEPTH)-1:0]), .wdata, .rdata(io_rd));

   mmbd_ram #(.WIDTH(BYTE_W), .DEPTH(HRAM_DEPTH)) u_hram (
      .clock, .en(en && sel.region == REGION_HRAM), .we,
      .addr(sel.index[$clog2(HRAM_DEPTH)-1:0]), .wdata, .rdata(hram_rd));

   assign ie_in = (en && we && sel.region == REGION_IE) ? wdata : ie_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ie_ff <= '0;
      end else begin
         ie_ff <= ie_in;
      end
   end

   // hold the region and the register byte of the last access for the read mux
   always_ff @(posedge clock) begin
      if (en) begin
         region_ff <= sel.region;
         ie_rd_ff  <= ie_ff;
      end
   end

   always_comb begin
      unique case (region_ff)
         REGION_ROM0: rdata = rom0_rd;
         REGION_ROM1: rdata = rom1_rd;
         REGION_VRAM: rdata = vram_rd;
         REGION_WRAM: rdata = wram_rd;
         REGION_OAM:  rdata = oam_rd;
         REGION_IO:   rdata = io_rd;
         REGION_HRAM: rdata = hram_rd;
         REGION_IE:   rdata = ie_rd_ff;
         default:     rdata = '0;
      endcase
   end

endmodule

/* bench/tb_memory_map_bus_decoder_top.sv */
// Self-checking bench for memory_map_bus_decoder_top: drives byte bus accesses
// on the req_ stream and checks every rsp_ transfer against a local predictor.
// Depends on mmbd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_memory_map_bus_decoder_top;
   import mmbd_pkg::*;

   // Access kinds carried on req_tuser
   localparam bit ACT_READ  = 1'b0;
   localparam bit ACT_WRITE = 1'b1;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ACCESSES = 1450;
   // Worst honest quiet stretch is a receiver stall or a sender gap plus the
   // store read and the result register; this is far beyond either.
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;

   // One result transfer: byte read and the unmapped flag
   typedef struct packed {
      logic [7:0] read_data;
      logic       error;
   } bus_result_type;

   // One row of directed stimulus; pinned rows carry a hand-typed result
   typedef struct packed {
      bit          action;
      logic [15:0] address;
      logic [7:0]  wdata;
      bit          pinned;
      logic [7:0]  exp_read;
      bit          exp_error;
   } access_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] address, [23:16] write_data
   logic        req_tuser = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] read_data
   logic        rsp_tuser;        // [0] error

   // Travel alongside the request so the monitor knows which rows are pinned
   bit             access_pinned = 1'b0;
   bus_result_type access_pinned_result = '0;

   // Predictor's copy of every store in the map
   logic [7:0] rom0_image [ROM_DEPTH];
   logic [7:0] rom1_image [ROM_DEPTH];
   logic [7:0] vram_image [VRAM_DEPTH];
   logic [7:0] wram_image [WRAM_DEPTH];
   logic [7:0] oam_image  [OAM_DEPTH];
   logic [7:0] io_image   [IO_DEPTH];
   logic [7:0] hram_image [HRAM_DEPTH];
   logic [7:0] ie_image = '0;

   bus_result_type pending_results [$];
   int             fault_count = 0;

   // Stimulus-side bookkeeping: which cells hold a written byte
   bit          cell_written [int];
   logic [15:0] readable_addrs [$];
   int          burst_left = 0;

   access_row_type directed_rows [25] = '{
      // interrupt enable reads zero out of reset
      '{ACT_READ,  16'hffff, 8'h00, 1'b1, 8'h00, 1'b0},
      // unmapped regions, both edges, reads and writes
      '{ACT_READ,  16'ha000, 8'h00, 1'b1, 8'h00, 1'b1},
      '{ACT_WRITE, 16'hbfff, 8'hff, 1'b1, 8'h00, 1'b1},
      '{ACT_READ,  16'hfea0, 8'h00, 1'b1, 8'h00, 1'b1},
      '{ACT_WRITE, 16'hfeff, 8'h5a, 1'b1, 8'h00, 1'b1},
      // writes at every region edge answer zero, no error
      '{ACT_WRITE, 16'h0000, 8'ha5, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'h3fff, 8'h5a, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'h4000, 8'hff, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'h7fff, 8'h01, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'h8000, 8'h80, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'h9fff, 8'h7f, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hc000, 8'hc3, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hdfff, 8'h3c, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hfdff, 8'he7, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hfe00, 8'h11, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hfe9f, 8'h22, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hff00, 8'h33, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hff7f, 8'h44, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hff80, 8'h55, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hfffe, 8'h66, 1'b1, 8'h00, 1'b0},
      '{ACT_WRITE, 16'hffff, 8'haa, 1'b1, 8'h00, 1'b0},
      // read back: ROM, echo of a WRAM write, WRAM behind an echo write, IE
      '{ACT_READ,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,  16'he000, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,  16'hddff, 8'h00, 1'b0, 8'h00, 1'b0},
      '{ACT_READ,  16'hffff, 8'h00, 1'b0, 8'h00, 1'b0}
   };

   memory_map_bus_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Decode a bus address into its store and the entry inside it.
   // The echo window lands on the same work RAM entry as its base address.
   function automatic mmbd_sel_type map_address(input logic [15:0] addr);
      mmbd_sel_type sel;
      sel.region = REGION_NONE;
      sel.index  = '0;
      if (addr <= 16'h3fff) begin
         sel.region = REGION_ROM0;
         sel.index  = addr[13:0];
      end else if (addr <= 16'h7fff) begin
         sel.region = REGION_ROM1;
         sel.index  = addr[13:0];
      end else if (addr <= 16'h9fff) begin
         sel.region = REGION_VRAM;
         sel.index  = INDEX_W'(addr[12:0]);
      end else if (addr <= 16'hbfff) begin
         sel.region = REGION_NONE;
      end else if (addr <= 16'hfdff) begin
         // 0xc000-0xdfff and its echo at 0xe000-0xfdff share the low 13 bits
         sel.region = REGION_WRAM;
         sel.index  = INDEX_W'(addr[12:0]);
      end else if (addr <= 16'hfe9f) begin
         sel.region = REGION_OAM;
         sel.index  = INDEX_W'(addr[7:0]);
      end else if (addr <= 16'hfeff) begin
         sel.region = REGION_NONE;
      end else if (addr <= 16'hff7f) begin
         sel.region = REGION_IO;
         sel.index  = INDEX_W'(addr[6:0]);
      end else if (addr <= 16'hfffe) begin
         sel.region = REGION_HRAM;
         sel.index  = INDEX_W'(addr[6:0]);
      end else begin
         sel.region = REGION_IE;
      end
      return sel;
   endfunction

   // Apply one access to the store images and return the result it causes
   function automatic bus_result_type predict_access(input bit is_write,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data);
      mmbd_sel_type   sel;
      bus_result_type res;
      logic [7:0]     cell_value;
      sel = map_address(addr);
      res = '0;
      cell_value = '0;
      if (sel.region == REGION_NONE) begin
         res.error = 1'b1;
      end else if (is_write) begin
         case (sel.region)
            REGION_ROM0: rom0_image[sel.index] = data;
            REGION_ROM1: rom1_image[sel.index] = data;
            REGION_VRAM: vram_image[sel.index] = data;
            REGION_WRAM: wram_image[sel.index] = data;
            REGION_OAM:  oam_image[sel.index]  = data;
            REGION_IO:   io_image[sel.index]   = data;
            REGION_HRAM: hram_image[sel.index] = data;
            default:     ie_image              = data;
         endcase
      end else begin
         case (sel.region)
            REGION_ROM0: cell_value = rom0_image[sel.index];
            REGION_ROM1: cell_value = rom1_image[sel.index];
            REGION_VRAM: cell_value = vram_image[sel.index];
            REGION_WRAM: cell_value = wram_image[sel.index];
            REGION_OAM:  cell_value = oam_image[sel.index];
            REGION_IO:   cell_value = io_image[sel.index];
            REGION_HRAM: cell_value = hram_image[sel.index];
            default:     cell_value = ie_image;
         endcase
         res.read_data = cell_value;
      end
      return res;
   endfunction

   // Present one access, hold it until the transfer, then maybe open a gap.
   // Called at a rising edge; returns at a rising edge.
   task automatic issue_access(input bit action, input logic [15:0] addr,
                               input logic [7:0] data, input bit pinned,
                               input bus_result_type pinned_result);
      mmbd_sel_type sel;
      int           key;
      int           gap;
      // Remember written cells so later reads never hit an undefined byte
      sel = map_address(addr);
      if (action == ACT_WRITE && sel.region != REGION_NONE) begin
         key = int'({sel.region, sel.index});
         if (!cell_written.exists(key)) begin
            cell_written[key] = 1'b1;
            readable_addrs.push_back(addr);
         end
      end
      req_tvalid           <= 1'b1;
      req_tuser            <= action;
      req_tdata            <= {data, addr};
      access_pinned        <= pinned;
      access_pinned_result <= pinned_result;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // Burst bookkeeping: at the end of a burst pick the next one and a gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Pick an address whose cell already holds a written byte; work RAM
   // cells under the echo window are reached through it half of the time
   function automatic logic [15:0] pick_readable();
      logic [15:0] addr;
      addr = readable_addrs[$urandom_range(0, readable_addrs.size() - 1)];
      if (addr >= 16'hc000 && addr <= 16'hddff && $urandom_range(0, 1) == 1)
         addr = addr + 16'h2000;
      else if (addr >= 16'he000 && addr <= 16'hfdff && $urandom_range(0, 1) == 1)
         addr = addr - 16'h2000;
      return addr;
   endfunction

   // Predict on every request transfer, check on every result transfer
   always @(posedge clock) begin
      bus_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = predict_access(req_tuser, req_tdata[15:0], req_tdata[23:16]);
            if (access_pinned)
               want = access_pinned_result;
            pending_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: read_data %h error %b",
                      rsp_tdata, rsp_tuser);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, rsp_tdata);
                  fault_count++;
               end
               if (rsp_tuser !== want.error) begin
                  $error("error mismatch: expected %b, actual %b",
                         want.error, rsp_tuser);
                  fault_count++;
               end
            end
         end
      end
   end

   // Receiver: change stall style at the end of each randomly sized span
   initial begin
      int mode;
      int span;
      int stall_left;
      stall_left = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         for (int cyc = 0; cyc < span; cyc++) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (cyc % 5 < 2);
               default: begin
                  // long stalls now and then, otherwise ready
                  if (stall_left > 0) begin
                     rsp_tready <= 1'b0;
                     stall_left--;
                  end else begin
                     rsp_tready <= 1'b1;
                     if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(4, 24);
                  end
               end
            endcase
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_memory_map_bus_decoder_top: done, errors");
      $finish;
   end

   // Main stimulus: reset, directed rows, then random accesses
   initial begin
      int          pick;
      logic [15:0] addr;
      logic [7:0]  data;
      bit          action;

      // interrupt enable is the only cell defined out of reset
      cell_written[int'({REGION_IE, INDEX_W'(0)})] = 1'b1;
      readable_addrs.push_back(16'hffff);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_access(directed_rows[i].action, directed_rows[i].address,
                      directed_rows[i].wdata, directed_rows[i].pinned,
                      bus_result_type'{directed_rows[i].exp_read,
                                       directed_rows[i].exp_error});

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         pick = $urandom_range(0, 99);
         data = 8'($urandom_range(0, 255));
         if (pick < 35) begin
            // write anywhere; bias toward the small stores near the top
            addr = ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(16'hfe00, 16'hffff));
            issue_access(ACT_WRITE, addr, data, 1'b0, '0);
         end else if (pick < 75) begin
            issue_access(ACT_READ, pick_readable(), data, 1'b0, '0);
         end else if (pick < 88) begin
            // unmapped: external RAM or the unusable gap, either action
            action = 1'($urandom_range(0, 1));
            addr = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'ha000, 16'hbfff))
                                               : 16'($urandom_range(16'hfea0, 16'hfeff));
            issue_access(action, addr, data, 1'b0, '0);
         end else if (pick < 94) begin
            action = 1'($urandom_range(0, 1));
            issue_access(action, 16'hffff, data, 1'b0, '0);
         end else begin
            // write then read straight back, possibly through the echo window
            addr = 16'($urandom_range(0, 65535));
            issue_access(ACT_WRITE, addr, data, 1'b0, '0);
            if (map_address(addr).region == REGION_WRAM && addr <= 16'hddff
                && $urandom_range(0, 1) == 1)
               addr = addr + 16'h2000;
            issue_access(ACT_READ, addr, 8'($urandom_range(0, 255)), 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      // let the monitor record the last request transfer before draining
      @(posedge clock);

      // drain: the watchdog covers a result that never comes
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("tb_memory_map_bus_decoder_top: done, clean");
      else
         $display("tb_memory_map_bus_decoder_top: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
src/mmbd_pkg.sv
src/mmbd_ram.sv
src/mmbd_decode.sv
src/mmbd_store.sv
src/memory_map_bus_decoder_top.sv
bench/tb_memory_map_bus_decoder_top.sv
